// ===== hw/rtl/voxel_exposed_face_culler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Voxel exposed-face culler assertion macros
// Shorthand for the clocked assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_EXPOSED_FACE_CULLER_TOP_MACROS_SVH
`define VOXEL_EXPOSED_FACE_CULLER_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define VEFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is low.
`define VEFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset itself.
`define VEFC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/vefc_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel exposed-face culler package
// Grid geometry, item types, face and block codes, and the face palette.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vefc_pkg;

  localparam int SIZE_X = 16;
  localparam int SIZE_Y = 6;
  localparam int SIZE_Z = 16;
  localparam int CELLS  = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int ADDR_W = $clog2(CELLS);

  localparam int X_W = 4;
  localparam int Y_W = 3;
  localparam int Z_W = 4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [2:0] BLK_AIR      = 3'd0;
  localparam logic [2:0] BLK_KIND_MAX = 3'd5;

  typedef enum logic [2:0] {
    DIR_POS_Y,
    DIR_NEG_Y,
    DIR_POS_Z,
    DIR_NEG_Z,
    DIR_POS_X,
    DIR_NEG_X
  } face_dir_t;

  typedef struct packed {
    logic           func;
    logic [X_W-1:0] pos_x;
    logic [Y_W-1:0] pos_y;
    logic [Z_W-1:0] pos_z;
    logic [2:0]     block_type;
  } in_item_t;

  typedef struct packed {
    logic [X_W-1:0] face_x;
    logic [Y_W-1:0] face_y;
    logic [Z_W-1:0] face_z;
    logic [2:0]     face_dir;
    logic [2:0]     block_kind;
    logic [23:0]    face_color;
    logic           last;
  } out_item_t;

  // [type][class]: top, bottom, z sides, x sides
  localparam logic [23:0] PALETTE [0:5][0:3] = '{
    '{24'h000000, 24'h000000, 24'h000000, 24'h000000},
    '{24'h529B30, 24'h3C2C1C, 24'h644828, 24'h583E22},
    '{24'h6E4C2C, 24'h46321C, 24'h684628, 24'h5A3C22},
    '{24'h949494, 24'h5A5A5A, 24'h7D7D7D, 24'h6E6E6E},
    '{24'h50341C, 24'h442C18, 24'h644020, 24'h58381C},
    '{24'h347822, 24'h28641C, 24'h306E1E, 24'h2C691C}
  };

  function automatic logic [23:0] face_color(input logic [2:0] kind, input face_dir_t dir);
    logic [1:0] cls;
    unique case (dir)
      DIR_POS_Y:            cls = 2'd0;
      DIR_NEG_Y:            cls = 2'd1;
      DIR_POS_Z, DIR_NEG_Z: cls = 2'd2;
      default:              cls = 2'd3;
    endcase
    if (kind > BLK_KIND_MAX) begin
      return 24'h000000;
    end
    return PALETTE[kind][cls];
  endfunction

  // Coordinates carry one extra bit so a step below zero lands out of range.
  function automatic logic in_grid(input logic [X_W:0] x, input logic [Y_W:0] y,
                                   input logic [Z_W:0] z);
    return (x < (X_W+1)'(SIZE_X)) && (y < (Y_W+1)'(SIZE_Y)) && (z < (Z_W+1)'(SIZE_Z));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W:0] x,
                                                  input logic [Y_W:0] y,
                                                  input logic [Z_W:0] z);
    int unsigned lin;
    lin = (int'(x) * SIZE_Y + int'(y)) * SIZE_Z + int'(z);
    return ADDR_W'(lin);
  endfunction

endpackage

// ===== hw/rtl/voxel_exposed_face_culler_top.sv =====
// ----------------------------------------------------------------------------
// Voxel exposed-face culler
// Voxel grid in block RAM; a query emits one transaction per exposed face.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | vefc_pkg::in_item_t
//   out_    | output    | out_valid / out_ready| vefc_pkg::out_item_t
//
// A write goes into the grid RAM in the cycle it is accepted. A query issues six
// read beats on the grid RAM (self plus +y on the first, one neighbor on each of
// the others), with in_ready low until the last is issued; faces leave at one per
// cycle while out_ready is high. After reset a clearing pass writes air to all
// 1536 cells, one per cycle, with in_ready low. A stalled output holds one
// query in the emitter, one in the hold stage and a third at its last grid
// read, and then input stalls.
`timescale 1ns / 1ps

module voxel_exposed_face_culler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vefc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vefc_pkg::out_item_t out_data
);

  localparam int AW = vefc_pkg::ADDR_W;
  localparam int XW = vefc_pkg::X_W;
  localparam int YW = vefc_pkg::Y_W;
  localparam int ZW = vefc_pkg::Z_W;

  // grid RAM
  logic [2:0] mem [vefc_pkg::CELLS];
  logic [2:0] rd_a_r;
  logic [2:0] rd_b_r;

  // clearing pass
  logic          clr_active_r, clr_active_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  // query sequencer
  logic                seq_active_r, seq_active_nxt;
  vefc_pkg::face_dir_t seq_beat_r, seq_beat_nxt;
  logic [XW-1:0]       seq_x_r;
  logic [YW-1:0]       seq_y_r;
  logic [ZW-1:0]       seq_z_r;

  // read-data stage
  logic                b_valid_r, b_valid_nxt;
  vefc_pkg::face_dir_t b_beat_r;
  logic                b_nb_in_r;
  logic                b_self_in_r;
  logic [XW-1:0]       b_x_r;
  logic [YW-1:0]       b_y_r;
  logic [ZW-1:0]       b_z_r;

  // collector
  logic [2:0] col_kind_r;
  logic [5:0] col_mask_r;

  // hold stage
  logic          hold_valid_r, hold_valid_nxt;
  logic [5:0]    hold_mask_r;
  logic [2:0]    hold_kind_r;
  logic [XW-1:0] hold_x_r;
  logic [YW-1:0] hold_y_r;
  logic [ZW-1:0] hold_z_r;

  // emitter
  logic          em_valid_r, em_valid_nxt;
  logic [5:0]    em_mask_r, em_mask_nxt;
  logic [2:0]    em_kind_r;
  logic [XW-1:0] em_x_r;
  logic [YW-1:0] em_y_r;
  logic [ZW-1:0] em_z_r;

  logic                in_fire, q_start, issue_go, b_stall, b_fire, b_final;
  vefc_pkg::face_dir_t iss_beat;
  logic [XW-1:0]       iss_x;
  logic [YW-1:0]       iss_y;
  logic [ZW-1:0]       iss_z;
  logic [XW:0]         nx;
  logic [YW:0]         ny;
  logic [ZW:0]         nz;
  logic                nb_in, self_in, wr_in;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [2:0]          wr_data;
  logic                b_exposed;
  logic [5:0]          fin_mask;
  logic                hold_push, em_load, em_last, out_fire;
  vefc_pkg::face_dir_t em_sel;

  // ---------------- issue ----------------
  assign b_final  = (b_beat_r == vefc_pkg::DIR_NEG_X);
  assign b_stall  = b_valid_r && b_final && hold_valid_r;
  assign b_fire   = b_valid_r && !b_stall;
  assign in_ready = !clr_active_r && !seq_active_r && !b_stall;
  assign in_fire  = in_valid && in_ready;
  assign q_start  = in_fire && (in_data.func == vefc_pkg::FUNC_QUERY);
  assign issue_go = q_start || (seq_active_r && !b_stall);

  assign iss_x    = q_start ? in_data.pos_x : seq_x_r;
  assign iss_y    = q_start ? in_data.pos_y : seq_y_r;
  assign iss_z    = q_start ? in_data.pos_z : seq_z_r;
  assign iss_beat = q_start ? vefc_pkg::DIR_POS_Y : seq_beat_r;

  always_comb begin
    nx = {1'b0, iss_x};
    ny = {1'b0, iss_y};
    nz = {1'b0, iss_z};
    unique case (iss_beat)
      vefc_pkg::DIR_POS_Y: ny = ny + 1'b1;
      vefc_pkg::DIR_NEG_Y: ny = ny - 1'b1;
      vefc_pkg::DIR_POS_Z: nz = nz + 1'b1;
      vefc_pkg::DIR_NEG_Z: nz = nz - 1'b1;
      vefc_pkg::DIR_POS_X: nx = nx + 1'b1;
      vefc_pkg::DIR_NEG_X: nx = nx - 1'b1;
      default: ;
    endcase
  end

  assign nb_in   = vefc_pkg::in_grid(nx, ny, nz);
  assign self_in = vefc_pkg::in_grid({1'b0, iss_x}, {1'b0, iss_y}, {1'b0, iss_z});
  assign wr_in   = vefc_pkg::in_grid({1'b0, in_data.pos_x}, {1'b0, in_data.pos_y},
                                     {1'b0, in_data.pos_z});

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr_r;
    wr_data = vefc_pkg::BLK_AIR;
    if (clr_active_r) begin
      wr_en = 1'b1;
    end else if (in_fire && (in_data.func == vefc_pkg::FUNC_WRITE) && wr_in &&
                 (in_data.block_type <= vefc_pkg::BLK_KIND_MAX)) begin
      wr_en   = 1'b1;
      wr_addr = vefc_pkg::cell_addr({1'b0, in_data.pos_x}, {1'b0, in_data.pos_y},
                                    {1'b0, in_data.pos_z});
      wr_data = in_data.block_type;
    end
  end

  // Reads launch in issue order, so a query never sees a later write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue_go) begin
      rd_a_r <= mem[vefc_pkg::cell_addr(nx, ny, nz)];
    end
    if (q_start) begin
      rd_b_r <= mem[vefc_pkg::cell_addr({1'b0, iss_x}, {1'b0, iss_y}, {1'b0, iss_z})];
    end
  end

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(vefc_pkg::CELLS - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    seq_active_nxt = seq_active_r;
    seq_beat_nxt   = seq_beat_r;
    if (q_start) begin
      seq_active_nxt = 1'b1;
      seq_beat_nxt   = vefc_pkg::DIR_NEG_Y;
    end else if (seq_active_r && !b_stall) begin
      seq_beat_nxt = vefc_pkg::face_dir_t'(seq_beat_r + 3'd1);
      if (seq_beat_r == vefc_pkg::DIR_NEG_X) begin
        seq_active_nxt = 1'b0;
      end
    end
  end

  assign b_valid_nxt = b_stall ? b_valid_r : issue_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      seq_active_r <= 1'b0;
      seq_beat_r   <= vefc_pkg::DIR_POS_Y;
      b_valid_r    <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      seq_active_r <= seq_active_nxt;
      seq_beat_r   <= seq_beat_nxt;
      b_valid_r    <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_start) begin
      seq_x_r <= in_data.pos_x;
      seq_y_r <= in_data.pos_y;
      seq_z_r <= in_data.pos_z;
    end
    if (issue_go) begin
      b_beat_r    <= iss_beat;
      b_nb_in_r   <= nb_in;
      b_self_in_r <= self_in;
      b_x_r       <= iss_x;
      b_y_r       <= iss_y;
      b_z_r       <= iss_z;
    end
  end

  // ---------------- collect ----------------
  assign b_exposed = !b_nb_in_r || (rd_a_r == vefc_pkg::BLK_AIR);
  assign fin_mask  = {b_exposed, col_mask_r[4:0]};
  assign hold_push = b_fire && b_final && (col_kind_r != vefc_pkg::BLK_AIR) &&
                     (fin_mask != 6'd0);

  always_ff @(posedge clk) begin
    if (b_fire) begin
      col_mask_r[b_beat_r] <= b_exposed;
      if (b_beat_r == vefc_pkg::DIR_POS_Y) begin
        col_kind_r <= b_self_in_r ? rd_b_r : vefc_pkg::BLK_AIR;
      end
    end
    if (hold_push) begin
      hold_mask_r <= fin_mask;
      hold_kind_r <= col_kind_r;
      hold_x_r    <= b_x_r;
      hold_y_r    <= b_y_r;
      hold_z_r    <= b_z_r;
    end
  end

  // ---------------- emit ----------------
  always_comb begin
    em_sel = vefc_pkg::DIR_NEG_X;
    for (int i = 5; i >= 0; i--) begin
      if (em_mask_r[i]) begin
        em_sel = vefc_pkg::face_dir_t'(3'(i));
      end
    end
  end

  assign em_last  = ((em_mask_r & (em_mask_r - 6'd1)) == 6'd0);
  assign out_fire = em_valid_r && out_ready;
  assign em_load  = hold_valid_r && (!em_valid_r || (out_fire && em_last));

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (em_load) begin
      hold_valid_nxt = 1'b0;
    end else if (hold_push) begin
      hold_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    em_valid_nxt = em_valid_r;
    em_mask_nxt  = em_mask_r;
    if (em_load) begin
      em_valid_nxt = 1'b1;
      em_mask_nxt  = hold_mask_r;
    end else if (out_fire) begin
      em_mask_nxt = em_mask_r & (em_mask_r - 6'd1);
      if (em_last) begin
        em_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      em_valid_r   <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      em_valid_r   <= em_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_mask_r <= em_mask_nxt;
    if (em_load) begin
      em_kind_r <= hold_kind_r;
      em_x_r    <= hold_x_r;
      em_y_r    <= hold_y_r;
      em_z_r    <= hold_z_r;
    end
  end

  assign out_valid           = em_valid_r;
  assign out_data.face_x     = em_x_r;
  assign out_data.face_y     = em_y_r;
  assign out_data.face_z     = em_z_r;
  assign out_data.face_dir   = 3'(em_sel);
  assign out_data.block_kind = em_kind_r;
  assign out_data.face_color = vefc_pkg::face_color(em_kind_r, em_sel);
  assign out_data.last       = em_last;

endmodule

// ===== hw/rtl/vefc_checker.sv =====
// ----------------------------------------------------------------------------
// Voxel exposed-face culler port checker
// Watches the top-level ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "voxel_exposed_face_culler_top_macros.svh"

module vefc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input vefc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input vefc_pkg::out_item_t out_data
);

  `VEFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out transaction changed while stalled")

  `VEFC_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid && !in_ready, "ports active right after reset")

  `VEFC_ASSERT_NEXT(a_query_busy, in_valid && in_ready && in_data.func == vefc_pkg::FUNC_QUERY, !in_ready, "input taken during query issue")

  `VEFC_ASSERT_NEXT(a_faces_burst, out_valid && out_ready && !out_data.last, out_valid, "gap inside a face burst")

  `VEFC_ASSERT_NOW(a_solid_kind, out_valid, out_data.block_kind != vefc_pkg::BLK_AIR, "face emitted for air")

endmodule

bind voxel_exposed_face_culler_top vefc_checker u_vefc_checker (.*);

// ===== tb/vefc_face_checker.sv =====
// ----------------------------------------------------------------------------
// Voxel exposed-face culler checker
// Watches both channels, keeps its own copy of the voxel grid, predicts the
// face transactions of every accepted query and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vefc_face_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  vefc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  vefc_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  faces_pending,
  output int                  writes_seen,
  output int                  queries_seen,
  output int                  faces_seen
);
  import vefc_pkg::*;

  logic [2:0] grid_model [CELLS];
  out_item_t  face_queue [$];

  function automatic logic on_grid(input int x, input int y, input int z);
    return x >= 0 && x < SIZE_X && y >= 0 && y < SIZE_Y && z >= 0 && z < SIZE_Z;
  endfunction

  function automatic int cell_pos(input int x, input int y, input int z);
    return (x * SIZE_Y + y) * SIZE_Z + z;
  endfunction

  // Anything off the grid reads as air.
  function automatic logic [2:0] kind_at(input int x, input int y, input int z);
    if (!on_grid(x, y, z)) begin
      return BLK_AIR;
    end
    return grid_model[cell_pos(x, y, z)];
  endfunction

  task automatic apply_item(input in_item_t item);
    int x, y, z, nx, ny, nz, first;
    logic [2:0] kind;
    logic [1:0] shade;
    face_dir_t  dir;
    out_item_t  face;
    x = int'(item.pos_x);
    y = int'(item.pos_y);
    z = int'(item.pos_z);
    if (item.func == FUNC_WRITE) begin
      writes_seen++;
      // drop writes off the grid or of unknown types
      if (on_grid(x, y, z) && item.block_type <= BLK_KIND_MAX) begin
        grid_model[cell_pos(x, y, z)] = item.block_type;
      end
      return;
    end
    queries_seen++;
    kind = kind_at(x, y, z);
    if (kind == BLK_AIR || kind > BLK_KIND_MAX) begin
      return;
    end
    first = face_queue.size();
    for (int f = 0; f < 6; f++) begin
      dir = face_dir_t'(f);
      nx  = x;
      ny  = y;
      nz  = z;
      case (dir)
        DIR_POS_Y: begin
          ny = y + 1;
          shade = 2'd0;
        end
        DIR_NEG_Y: begin
          ny = y - 1;
          shade = 2'd1;
        end
        DIR_POS_Z: begin
          nz = z + 1;
          shade = 2'd2;
        end
        DIR_NEG_Z: begin
          nz = z - 1;
          shade = 2'd2;
        end
        DIR_POS_X: begin
          nx = x + 1;
          shade = 2'd3;
        end
        default: begin
          nx = x - 1;
          shade = 2'd3;
        end
      endcase
      if (kind_at(nx, ny, nz) == BLK_AIR) begin
        face.face_x     = item.pos_x;
        face.face_y     = item.pos_y;
        face.face_z     = item.pos_z;
        face.face_dir   = dir;
        face.block_kind = kind;
        face.face_color = PALETTE[kind][shade];
        face.last       = 1'b0;
        face_queue.push_back(face);
      end
    end
    if (face_queue.size() > first) begin
      face_queue[face_queue.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (grid_model[i]) grid_model[i] = BLK_AIR;
      face_queue.delete();
      mismatches   = 0;
      writes_seen  = 0;
      queries_seen = 0;
      faces_seen   = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_item(in_data);
      end
      if (out_valid && out_ready) begin
        faces_seen++;
        if (face_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected face transaction: x=%0d y=%0d z=%0d dir=%0d kind=%0d",
                     out_data.face_x, out_data.face_y, out_data.face_z,
                     out_data.face_dir, out_data.block_kind);
          end
        end else begin
          want = face_queue.pop_front();
          if (out_data.face_x !== want.face_x || out_data.face_y !== want.face_y ||
              out_data.face_z !== want.face_z || out_data.face_dir !== want.face_dir ||
              out_data.block_kind !== want.block_kind ||
              out_data.face_color !== want.face_color || out_data.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("face mismatch: expected x=%0d y=%0d z=%0d dir=%0d kind=%0d color=%06h last=%0b",
                       want.face_x, want.face_y, want.face_z, want.face_dir,
                       want.block_kind, want.face_color, want.last);
              $display("               got      x=%0d y=%0d z=%0d dir=%0d kind=%0d color=%06h last=%0b",
                       out_data.face_x, out_data.face_y, out_data.face_z, out_data.face_dir,
                       out_data.block_kind, out_data.face_color, out_data.last);
            end
          end
        end
      end
    end
    faces_pending <= face_queue.size();
  end

endmodule

// ===== tb/tb_voxel_exposed_face_culler_top.sv =====
// ----------------------------------------------------------------------------
// Voxel exposed-face culler testbench
// Drives writes and face queries with random idling on both channels and a
// long output hold-off; the checker module predicts and compares the faces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_voxel_exposed_face_culler_top;
  import vefc_pkg::*;

  localparam int IDLE_PCT        = 38;
  localparam int RANDOM_ITEMS    = 128;
  localparam int HOLD_OFF_CYCLES = 300;

  logic      clk          = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // shared between the sender and receiver processes
  logic steady       = 1'b0;
  logic hold_off_req = 1'b0;

  int mismatches, faces_pending, writes_seen, queries_seen, faces_seen;

  always #2 clk = ~clk;

  voxel_exposed_face_culler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  vefc_face_checker face_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .faces_pending (faces_pending),
    .writes_seen   (writes_seen),
    .queries_seen  (queries_seen),
    .faces_seen    (faces_seen)
  );

  initial begin
    #2_000_000;
    $display("tb_voxel_exposed_face_culler_top: FAIL");
    $finish;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    logic held;
    held = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic in_item_t make_item(input logic func, input int x, input int y,
                                         input int z, input int kind);
    in_item_t item;
    item.func       = func;
    item.pos_x      = 4'(x);
    item.pos_y      = 3'(y);
    item.pos_z      = 4'(z);
    item.block_type = 3'(kind);
    return item;
  endfunction

  // Mostly clustered near two grid corners so neighbors are often solid.
  function automatic in_item_t random_item();
    in_item_t item;
    logic     far_corner;
    item.func = ($urandom_range(0, 99) < 55) ? FUNC_QUERY : FUNC_WRITE;
    if ($urandom_range(0, 99) < 75) begin
      far_corner = 1'($urandom_range(0, 1));
      item.pos_x = far_corner ? 4'(12 + $urandom_range(0, 3)) : 4'($urandom_range(0, 3));
      item.pos_y = far_corner ? 3'($urandom_range(3, 5)) : 3'($urandom_range(0, 2));
      item.pos_z = far_corner ? 4'(12 + $urandom_range(0, 3)) : 4'($urandom_range(0, 3));
    end else begin
      item.pos_x = 4'($urandom);
      item.pos_y = 3'($urandom);
      item.pos_z = 4'($urandom);
    end
    item.block_type = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, 5));
    return item;
  endfunction

  // Offer one transaction and return at the edge that accepts it.
  task automatic send_item(input in_item_t item);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // air block after reset
    send_item(make_item(FUNC_QUERY, 0, 0, 0, 0));
    // lone corner blocks: every face exposed, three of them against the grid edge
    send_item(make_item(FUNC_WRITE, 0, 0, 0, 1));
    send_item(make_item(FUNC_QUERY, 0, 0, 0, 7));
    send_item(make_item(FUNC_WRITE, 15, 5, 15, 5));
    send_item(make_item(FUNC_QUERY, 15, 5, 15, 0));
    // writes and queries off the grid
    send_item(make_item(FUNC_WRITE, 3, 6, 3, 3));
    send_item(make_item(FUNC_WRITE, 3, 7, 3, 3));
    send_item(make_item(FUNC_QUERY, 3, 6, 3, 0));
    send_item(make_item(FUNC_QUERY, 3, 7, 3, 0));
    // unknown block types must not overwrite the grass
    send_item(make_item(FUNC_WRITE, 0, 0, 0, 6));
    send_item(make_item(FUNC_WRITE, 0, 0, 0, 7));
    send_item(make_item(FUNC_QUERY, 0, 0, 0, 0));
    // enclosed rock block, then one of its neighbors
    send_item(make_item(FUNC_WRITE, 5, 2, 5, 3));
    send_item(make_item(FUNC_WRITE, 5, 3, 5, 1));
    send_item(make_item(FUNC_WRITE, 5, 1, 5, 2));
    send_item(make_item(FUNC_WRITE, 5, 2, 6, 4));
    send_item(make_item(FUNC_WRITE, 5, 2, 4, 2));
    send_item(make_item(FUNC_WRITE, 6, 2, 5, 5));
    send_item(make_item(FUNC_WRITE, 4, 2, 5, 3));
    send_item(make_item(FUNC_QUERY, 5, 2, 5, 0));
    send_item(make_item(FUNC_QUERY, 5, 3, 5, 0));
    // clear a block back to air
    send_item(make_item(FUNC_WRITE, 0, 0, 0, 0));
    send_item(make_item(FUNC_QUERY, 0, 0, 0, 0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 50 && i < 90);
      if (i == 90) begin
        hold_off_req = 1'b1;
      end
      send_item(random_item());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // let the count pick up the last accepted transaction before draining
    @(posedge clk);
    while (faces_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d writes and %0d queries, %0d face transactions checked,",
             writes_seen, queries_seen, faces_seen);
    $display("with random idling, an idle-free stretch and a %0d-cycle output hold-off",
             HOLD_OFF_CYCLES);
    if (mismatches == 0 && faces_pending == 0) begin
      $display("tb_voxel_exposed_face_culler_top: PASS");
    end else begin
      $display("tb_voxel_exposed_face_culler_top: FAIL");
    end
    $finish;
  end

endmodule
